// File: hdl/vbf_pkg.sv
package vbf_pkg;

    localparam int DIM_W      = 9;
    localparam int OFF_W      = 8;
    localparam int MAX_DIM    = 256;
    localparam int FRAC_BITS  = 8;
    localparam int SUM_W      = 38;
    localparam int CNT_W      = 25;
    localparam int RMSE_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int DIST_W     = $clog2(MAX_DIM / 2);
    localparam int SQ_W       = 2 * DIST_W;
    localparam int DIV_W      = SUM_W + 2 * FRAC_BITS;
    localparam int ROOT_IN_W  = 2 * RMSE_W;

    localparam logic [DIM_W-1:0]  DIM_RESET = DIM_W'(256);
    localparam logic [RMSE_W-1:0] RMSE_MAX  = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LENGTH = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SNAP,
        ST_DIV,
        ST_ROOT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic clear;
    } t_acc_ctl;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } t_acc_stat;

endpackage

// File: hdl/voxel_box_face_rmse_core.sv
// Box-face distance RMS core. Each occupied voxel inside the configured box adds the square
// of its face distance less one (floored at zero) to a running sum and bumps a count; the
// request flagged last_voxel returns count, sum and floor(sqrt(sum/count) * 256), saturated
// at 32767 and zero for an empty box, then clears the sum and the count. A voxel request
// holds the core as the bit-serial squarer takes one bit of the 7-bit distance per cycle,
// then accumulates and returns to idle. A last voxel goes on through a snapshot state,
// the restoring divider (one quotient bit of the 54-bit scaled sum per cycle, then a done
// strobe), the digit-serial root (15 result bits, then a done strobe) and an output state
// that loads the result register once it is free or being read. The result register lets
// new voxels enter while a result waits. The user must write box registers through the
// cfg port only while the core is idle; the core does not enforce it.
module voxel_box_face_rmse_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vbf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [vbf_pkg::DIM_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [vbf_pkg::OFF_W-1:0]      i_off_x,
    input  logic [vbf_pkg::OFF_W-1:0]      i_off_y,
    input  logic [vbf_pkg::OFF_W-1:0]      i_off_z,
    input  logic                           i_occupied,
    input  logic                           i_last_voxel,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [vbf_pkg::RMSE_W-1:0]     o_rmse_q8,
    output logic [vbf_pkg::CNT_W-1:0]      o_voxel_count,
    output logic [vbf_pkg::SUM_W-1:0]      o_square_sum
);

    localparam int DIV_W  = vbf_pkg::DIV_W;
    localparam int IN_W   = vbf_pkg::ROOT_IN_W;

    vbf_pkg::t_state    r_state, n_state;
    vbf_pkg::t_acc_ctl  w_acc_ctl;
    vbf_pkg::t_acc_stat w_acc_stat;

    logic [vbf_pkg::DIM_W-1:0]  r_dim_x, r_dim_y, r_dim_z;
    logic                       r_last;
    logic                       r_over;
    logic [vbf_pkg::SUM_W-1:0]  r_snap_sum;
    logic [vbf_pkg::CNT_W-1:0]  r_snap_cnt;
    logic                       r_out_valid;
    logic [vbf_pkg::RMSE_W-1:0] r_rmse;
    logic [vbf_pkg::CNT_W-1:0]  r_count;
    logic [vbf_pkg::SUM_W-1:0]  r_sum;

    logic                       w_accept, w_div_start, w_div_done, w_root_start, w_root_done;
    logic                       w_out_load;
    logic [DIV_W-1:0]           w_quo;
    logic [vbf_pkg::RMSE_W-1:0] w_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= vbf_pkg::DIM_RESET;
            r_dim_y <= vbf_pkg::DIM_RESET;
            r_dim_z <= vbf_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vbf_pkg::CFG_LENGTH: r_dim_x <= i_cfg_data;
                vbf_pkg::CFG_WIDTH:  r_dim_y <= i_cfg_data;
                vbf_pkg::CFG_HEIGHT: r_dim_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vbf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vbf_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = vbf_pkg::ST_SQUARE;
            end
            vbf_pkg::ST_SQUARE: begin
                if (w_acc_stat.done) n_state = r_last ? vbf_pkg::ST_SNAP : vbf_pkg::ST_IDLE;
            end
            vbf_pkg::ST_SNAP: begin
                n_state = vbf_pkg::ST_DIV;
            end
            vbf_pkg::ST_DIV: begin
                if (w_div_done) n_state = vbf_pkg::ST_ROOT;
            end
            vbf_pkg::ST_ROOT: begin
                if (w_root_done) n_state = vbf_pkg::ST_OUT;
            end
            vbf_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) n_state = vbf_pkg::ST_IDLE;
            end
            default: n_state = vbf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == vbf_pkg::ST_IDLE);
        w_accept        = o_in_ready && i_in_valid;
        w_acc_ctl.start = w_accept;
        w_acc_ctl.clear = (r_state == vbf_pkg::ST_SNAP);
        w_div_start     = (r_state == vbf_pkg::ST_SNAP);
        w_root_start    = (r_state == vbf_pkg::ST_DIV) && w_div_done;
        w_out_load      = (r_state == vbf_pkg::ST_OUT) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_last <= i_last_voxel;
        end
        if (w_div_start) begin
            r_snap_sum <= w_acc_stat.sum;
            r_snap_cnt <= w_acc_stat.count;
        end
        if (w_root_start) begin
            r_over <= |w_quo[DIV_W-1:IN_W];
        end
        if (w_out_load) begin
            r_count <= r_snap_cnt;
            r_sum   <= r_snap_sum;
            if (r_snap_cnt == '0) begin
                r_rmse <= '0;
            end else begin
                r_rmse <= r_over ? vbf_pkg::RMSE_MAX : w_root;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    vbf_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_acc_ctl),
        .i_off_x    (i_off_x),
        .i_off_y    (i_off_y),
        .i_off_z    (i_off_z),
        .i_occupied (i_occupied),
        .i_dim_x    (r_dim_x),
        .i_dim_y    (r_dim_y),
        .i_dim_z    (r_dim_z),
        .o_stat     (w_acc_stat)
    );

    vbf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   ({w_acc_stat.sum, (2 * vbf_pkg::FRAC_BITS)'(0)}),
        .i_den   (w_acc_stat.count),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    vbf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_rad   (w_quo[IN_W-1:0]),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    assign o_out_valid   = r_out_valid;
    assign o_rmse_q8     = r_rmse;
    assign o_voxel_count = r_count;
    assign o_square_sum  = r_sum;

endmodule

// File: hdl/vbf_accum.sv
module vbf_accum (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  vbf_pkg::t_acc_ctl          i_ctl,
    input  logic [vbf_pkg::OFF_W-1:0]  i_off_x,
    input  logic [vbf_pkg::OFF_W-1:0]  i_off_y,
    input  logic [vbf_pkg::OFF_W-1:0]  i_off_z,
    input  logic                       i_occupied,
    input  logic [vbf_pkg::DIM_W-1:0]  i_dim_x,
    input  logic [vbf_pkg::DIM_W-1:0]  i_dim_y,
    input  logic [vbf_pkg::DIM_W-1:0]  i_dim_z,
    output vbf_pkg::t_acc_stat         o_stat
);

    localparam int DIM_W  = vbf_pkg::DIM_W;
    localparam int DIST_W = vbf_pkg::DIST_W;
    localparam int SQ_W   = vbf_pkg::SQ_W;
    localparam int SUM_W  = vbf_pkg::SUM_W;
    localparam int CNT_W  = vbf_pkg::CNT_W;
    localparam int STEP_W = (DIST_W > 1) ? $clog2(DIST_W) : 1;
    localparam logic [DIM_W-1:0] MAX_D = DIM_W'(vbf_pkg::MAX_DIM);

    function automatic logic [DIM_W-1:0] f_min(input logic [DIM_W-1:0] a,
                                               input logic [DIM_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [DIM_W-1:0] f_eff(input logic [DIM_W-1:0] dim);
        return (dim > MAX_D) ? MAX_D : dim;
    endfunction

    logic [DIM_W-1:0]  w_lx, w_ly, w_lz;
    logic [DIM_W-1:0]  w_x, w_y, w_z;
    logic [DIM_W-1:0]  w_near;
    logic [DIST_W-1:0] w_d, w_dred;
    logic              w_hit;
    logic [SUM_W:0]    w_sum_ext;

    logic              r_busy, r_fin, r_hit;
    logic [STEP_W-1:0] r_step;
    logic [SQ_W-1:0]   r_mcand, r_prod;
    logic [DIST_W-1:0] r_mplier;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_count;

    always_comb begin
        w_lx   = f_eff(i_dim_x);
        w_ly   = f_eff(i_dim_y);
        w_lz   = f_eff(i_dim_z);
        w_x    = DIM_W'(i_off_x);
        w_y    = DIM_W'(i_off_y);
        w_z    = DIM_W'(i_off_z);
        w_hit  = i_occupied && (w_x < w_lx) && (w_y < w_ly) && (w_z < w_lz);
        w_near = f_min(f_min(f_min(w_x, w_lx - DIM_W'(1) - w_x),
                             f_min(w_y, w_ly - DIM_W'(1) - w_y)),
                       f_min(w_z, w_lz - DIM_W'(1) - w_z));
        w_d    = w_near[DIST_W-1:0];
        w_dred = (w_d == '0) ? '0 : w_d - DIST_W'(1);
        w_sum_ext = {1'b0, r_sum} + (SUM_W+1)'(r_prod);
    end

    // shift-add squarer, one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(DIST_W - 1)) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
            if (i_ctl.clear) begin
                r_sum   <= '0;
                r_count <= '0;
            end else if (r_fin && r_hit) begin
                r_sum   <= w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];
                r_count <= (r_count == '1) ? r_count : r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_hit    <= w_hit;
            r_mcand  <= SQ_W'(w_dred);
            r_mplier <= w_dred;
            r_prod   <= '0;
            r_step   <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
            r_step   <= r_step + STEP_W'(1);
        end
    end

    assign o_stat.done  = r_fin;
    assign o_stat.sum   = r_sum;
    assign o_stat.count = r_count;

endmodule

// File: hdl/vbf_div.sv
module vbf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [vbf_pkg::DIV_W-1:0]  i_num,
    input  logic [vbf_pkg::CNT_W-1:0]  i_den,
    output logic                       o_done,
    output logic [vbf_pkg::DIV_W-1:0]  o_quo
);

    localparam int DIV_W  = vbf_pkg::DIV_W;
    localparam int CNT_W  = vbf_pkg::CNT_W;
    localparam int STEP_W = $clog2(DIV_W);

    logic [CNT_W:0]    w_part;
    logic              w_ge;
    logic [CNT_W:0]    w_diff;

    logic              r_busy, r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem, r_den;
    logic [DIV_W-1:0]  r_quo;

    always_comb begin
        w_part = {r_rem, r_quo[DIV_W-1]};
        w_ge   = w_part >= {1'b0, r_den};
        w_diff = w_part - {1'b0, r_den};
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quo  <= i_num;
            r_step <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_part[CNT_W-1:0];
            r_quo  <= {r_quo[DIV_W-2:0], w_ge};
            r_step <= r_step + STEP_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// File: hdl/vbf_isqrt.sv
module vbf_isqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [vbf_pkg::ROOT_IN_W-1:0]  i_rad,
    output logic                           o_done,
    output logic [vbf_pkg::RMSE_W-1:0]     o_root
);

    localparam int IN_W   = vbf_pkg::ROOT_IN_W;
    localparam int R_W    = vbf_pkg::RMSE_W;
    localparam int REM_W  = R_W + 1;
    localparam int STEP_W = $clog2(R_W);

    logic [REM_W+1:0]  w_part, w_trial, w_diff;
    logic              w_ge;

    logic              r_busy, r_done;
    logic [STEP_W-1:0] r_step;
    logic [IN_W-1:0]   r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [R_W-1:0]    r_root;

    always_comb begin
        w_part  = {r_rem, r_rad[IN_W-1 -: 2]};
        w_trial = (REM_W+2)'({r_root, 2'b01});
        w_ge    = w_part >= w_trial;
        w_diff  = w_part - w_trial;
    end

    // digit-by-digit root, two radicand bits per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == STEP_W'(R_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_step <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_part[REM_W-1:0];
            r_root <= {r_root[R_W-2:0], w_ge};
            r_step <= r_step + STEP_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: hdl/vbf_chk.sv
module vbf_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  logic [vbf_pkg::RMSE_W-1:0]     o_rmse_q8,
    input  logic [vbf_pkg::CNT_W-1:0]      o_voxel_count,
    input  logic [vbf_pkg::SUM_W-1:0]      o_square_sum
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_rmse_q8) && $stable(o_voxel_count) && $stable(o_square_sum))
        else $error("result payload changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready held high after voxel request");

    a_empty_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_voxel_count == '0 |-> o_rmse_q8 == '0 && o_square_sum == '0)
        else $error("empty box result not zero");

endmodule

bind voxel_box_face_rmse_core vbf_chk u_vbf_chk (.*);
